### rtl/core/tssd_pkg.sv
// Shared types and constants of the touch slider swipe detector.
`timescale 1ns / 1ps
package tssd_pkg;

  localparam int unsigned RegIndexWidth = 8;
  localparam int unsigned RegValueWidth = 8;
  localparam logic [RegIndexWidth-1:0] RegSwipeThreshold = 8'd0;
  localparam logic [RegIndexWidth-1:0] RegTouchMinLevel = 8'd1;
  localparam logic [RegValueWidth-1:0] SwipeThresholdReset = 8'd40;
  localparam logic [RegValueWidth-1:0] TouchMinLevelReset = 8'd1;

  localparam int unsigned ScaleWidth = 7;
  localparam logic [ScaleWidth-1:0] CentroidScale = 7'd100;
  localparam int unsigned QuotBits = 7;
  localparam int unsigned PosWidth = 8;
  localparam int unsigned GestureWidth = 3;
  localparam int unsigned OutDataWidth = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [GestureWidth-1:0] {
    GestNone     = 3'd0,
    GestPress    = 3'd1,
    GestRelease  = 3'd2,
    GestForward  = 3'd3,
    GestBackward = 3'd4
  } gesture_e;

  typedef struct packed {
    logic [RegValueWidth-1:0] swipe_limit;
    logic [RegValueWidth-1:0] touch_min_level;
  } cfg_t;

endpackage

### rtl/core/tssd_front.sv
// Input stage: takes a sample, forms sum, peak test and scaled difference.
`timescale 1ns / 1ps
module tssd_front import tssd_pkg::*; #(
  parameter int unsigned LEVEL_WIDTH = 8,
  parameter int unsigned IN_DATA_W = 24,
  parameter int unsigned ENTRY_W = 2 * LEVEL_WIDTH + 11
) (
  input  cfg_t                 cfg_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [ENTRY_W-1:0]   q_data_o
);

  localparam int unsigned MagW = LEVEL_WIDTH + ScaleWidth;
  localparam int unsigned SumW = LEVEL_WIDTH + 2;
  localparam int unsigned CmpW = (LEVEL_WIDTH > RegValueWidth) ? LEVEL_WIDTH : RegValueWidth;

  logic [LEVEL_WIDTH-1:0] left_level, middle_level, right_level;
  logic [LEVEL_WIDTH-1:0] peak, peak_lm, diff_mag;
  logic [SumW-1:0]        sum;
  logic [MagW-1:0]        weighted_mag;
  logic                   neg, touched;

  assign left_level   = s_axis_tdata[0 +: LEVEL_WIDTH];
  assign middle_level = s_axis_tdata[LEVEL_WIDTH +: LEVEL_WIDTH];
  assign right_level  = s_axis_tdata[2*LEVEL_WIDTH +: LEVEL_WIDTH];

  always_comb begin
    sum = SumW'(left_level) + SumW'(middle_level) + SumW'(right_level);
    peak_lm = (middle_level > left_level) ? middle_level : left_level;
    peak = (right_level > peak_lm) ? right_level : peak_lm;
    touched = CmpW'(peak) >= CmpW'(cfg_i.touch_min_level);
    neg = left_level > right_level;
    diff_mag = neg ? (left_level - right_level) : (right_level - left_level);
    weighted_mag = MagW'(diff_mag) * MagW'(CentroidScale);
  end

  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;
  assign q_data_o      = {touched, neg, sum, weighted_mag};

endmodule

### rtl/core/tssd_queue.sv
// Short queue between the input stage and the divider and gesture stage.
`timescale 1ns / 1ps
module tssd_queue import tssd_pkg::*; #(
  parameter int unsigned DATA_W = 27
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/tssd_back.sv
// Divider for the centroid, gesture state machine and output register.
`timescale 1ns / 1ps
module tssd_back import tssd_pkg::*; #(
  parameter int unsigned LEVEL_WIDTH = 8,
  parameter int unsigned ENTRY_W = 2 * LEVEL_WIDTH + 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       q_valid_i,
  input  logic [ENTRY_W-1:0]         q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gesture_e                   gesture_o,
  output logic signed [PosWidth-1:0] position_o
);

  localparam int unsigned MagW = LEVEL_WIDTH + ScaleWidth;
  localparam int unsigned SumW = LEVEL_WIDTH + 2;
  localparam int unsigned DivW = SumW + QuotBits - 1;
  localparam int unsigned CntW = $clog2(QuotBits);

  typedef enum logic [1:0] {SWait, SDiv, SDone} step_e;
  typedef enum logic [1:0] {PIdle, PTouched, PSwiping} phase_e;

  step_e                       st_q, st_d;
  phase_e                      phase_q, phase_d;
  logic [MagW-1:0]             rem_q, rem_d;
  logic [DivW-1:0]             div_q, div_d;
  logic [QuotBits-1:0]         quot_q, quot_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        neg_q, neg_d, touched_q, touched_d, zero_q, zero_d;
  logic signed [PosWidth-1:0]  anchor_q, anchor_d, pos_q, pos_d;
  gesture_e                    gest_q, gest_d;
  logic                        out_valid_q, out_valid_d;

  logic [MagW-1:0]             in_mag;
  logic [SumW-1:0]             in_sum;
  logic                        ge, load;
  logic [PosWidth-1:0]         pos_abs;
  logic signed [PosWidth-1:0]  pos;
  logic signed [PosWidth:0]    delta;
  logic signed [PosWidth+1:0]  delta_x, thr_x;
  gesture_e                    gest;

  assign in_mag = q_data_i[0 +: MagW];
  assign in_sum = q_data_i[MagW +: SumW];
  assign q_pop_o = (st_q == SWait) & q_valid_i;
  assign ge = DivW'(rem_q) >= div_q;
  assign load = (st_q == SDone) & (~out_valid_q | out_ready_i);

  always_comb begin
    pos_abs = {1'b0, quot_q};
    if (zero_q) begin
      pos = '0;
    end else if (neg_q) begin
      pos = -$signed(pos_abs);
    end else begin
      pos = $signed(pos_abs);
    end
    delta = $signed({pos[PosWidth-1], pos}) - $signed({anchor_q[PosWidth-1], anchor_q});
    delta_x = {delta[PosWidth], delta};
    thr_x = $signed({2'b00, cfg_i.swipe_limit});
  end

  always_comb begin
    phase_d = phase_q;
    anchor_d = anchor_q;
    gest = GestNone;
    case (phase_q)
      PTouched: begin
        if (!touched_q) begin
          phase_d = PIdle;
          gest = GestRelease;
        end else if (delta_x > thr_x) begin
          phase_d = PSwiping;
          gest = GestForward;
        end else if (delta_x < -thr_x) begin
          phase_d = PSwiping;
          gest = GestBackward;
        end
      end
      PSwiping: begin
        if (!touched_q) begin
          phase_d = PIdle;
          gest = GestRelease;
        end
      end
      default: begin
        if (touched_q) begin
          phase_d = PTouched;
          anchor_d = pos;
          gest = GestPress;
        end else begin
          phase_d = PIdle;
        end
      end
    endcase
    if (!load) begin
      phase_d = phase_q;
      anchor_d = anchor_q;
    end
  end

  always_comb begin
    st_d = st_q;
    rem_d = rem_q;
    div_d = div_q;
    quot_d = quot_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    touched_d = touched_q;
    zero_d = zero_q;
    gest_d = gest_q;
    pos_d = pos_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (st_q)
      SWait: begin
        if (q_valid_i) begin
          rem_d = in_mag;
          div_d = DivW'(in_sum) << (QuotBits - 1);
          quot_d = '0;
          cnt_d = CntW'(QuotBits - 1);
          neg_d = q_data_i[MagW + SumW];
          touched_d = q_data_i[MagW + SumW + 1];
          zero_d = in_sum == '0;
          st_d = SDiv;
        end
      end
      SDiv: begin
        if (ge) begin
          rem_d = MagW'(DivW'(rem_q) - div_q);
        end
        quot_d = {quot_q[QuotBits-2:0], ge};
        div_d = div_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = SDone;
        end
      end
      SDone: begin
        if (load) begin
          gest_d = gest;
          pos_d = pos;
          out_valid_d = 1'b1;
          st_d = SWait;
        end
      end
      default: begin
        st_d = SWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SWait;
      phase_q <= PIdle;
      anchor_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      phase_q <= phase_d;
      anchor_q <= anchor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quot_q <= quot_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    touched_q <= touched_d;
    zero_q <= zero_d;
    gest_q <= gest_d;
    pos_q <= pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o = gest_q;
  assign position_o = pos_q;

`ifndef SYNTHESIS
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SDone && !zero_q) |-> (quot_q <= QuotBits'(100)))
    else $error("Centroid quotient out of range.");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("Output register overwritten.");
  a_swipe_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (gest == GestForward || gest == GestBackward)) |=> (phase_q == PSwiping))
    else $error("Swipe did not enter the swiping phase.");
  a_release_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && gest == GestRelease) |-> (phase_q != PIdle))
    else $error("Release reported while idle.");
`endif

endmodule

### rtl/core/touch_slider_swipe_detector_top.sv
// Top level of the touch slider swipe detector.
// The slave stream takes one sample of left, middle and right pad levels per item.
// The master stream returns exactly one item per sample: a gesture code and the
// centroid position, (right - left) * 100 / sum, truncated toward zero.
// The configuration channel writes the swipe threshold (index 0) and the minimum
// touch level (index 1); other indexes are ignored. It is always ready and should
// be written only while no sample is in flight.
// An accepted sample is written into the queue at once. The back stage then pops
// the sample, runs the restoring divider that forms the position one quotient bit
// a cycle, and loads the output register. It pops a new sample only after the
// previous result has been loaded into the output register.
// A two-entry queue lets new samples be accepted while the divider is busy or the
// output is stalled. When the receiver holds tready low the result waits in the
// output register and the divider holds its finished result.
// Reset clears the queue, the output valid flag, the touch phase (idle) and the
// anchor, and sets the registers to threshold 40 and minimum level 1.
`timescale 1ns / 1ps
module touch_slider_swipe_detector_top import tssd_pkg::*; #(
  parameter int unsigned LEVEL_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_level, middle_level, right_level, then zero fill to whole bytes
  input  logic [((3*LEVEL_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // gesture [2:0], position [10:3], zero fill [15:11]
  output logic [OutDataWidth-1:0]       m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [RegIndexWidth-1:0]      cfg_index_i,
  input  logic [RegValueWidth-1:0]      cfg_data_i
);

  localparam int unsigned InDataW = ((3 * LEVEL_WIDTH + 7) / 8) * 8;
  localparam int unsigned EntryW = 2 * LEVEL_WIDTH + 11;

  logic [RegValueWidth-1:0]   thr_q, thr_d, min_q, min_d;
  cfg_t                       cfg;
  logic                       q_full, q_push, q_valid, q_pop;
  logic [EntryW-1:0]          q_wdata, q_rdata;
  gesture_e                   gesture;
  logic signed [PosWidth-1:0] position;

  assign cfg_ready_o = 1'b1;
  assign cfg.swipe_limit = thr_q;
  assign cfg.touch_min_level = min_q;

  always_comb begin
    thr_d = thr_q;
    min_d = min_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSwipeThreshold: thr_d = cfg_data_i;
        RegTouchMinLevel:  min_d = cfg_data_i;
        default: begin
          thr_d = thr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= SwipeThresholdReset;
      min_q <= TouchMinLevelReset;
    end else begin
      thr_q <= thr_d;
      min_q <= min_d;
    end
  end

  tssd_front #(
    .LEVEL_WIDTH(LEVEL_WIDTH),
    .IN_DATA_W  (InDataW),
    .ENTRY_W    (EntryW)
  ) u_front (
    .cfg_i        (cfg),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  tssd_queue #(
    .DATA_W(EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  tssd_back #(
    .LEVEL_WIDTH(LEVEL_WIDTH),
    .ENTRY_W    (EntryW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .gesture_o  (gesture),
    .position_o (position)
  );

  assign m_axis_tdata = OutDataWidth'({position, gesture});

endmodule
